/* hw/rtl/hrdp_pkg.sv */
// Package for the HID report descriptor parser.
// Holds the transaction types, item codes and shared constants; no dependencies.
`default_nettype none

package hrdp_pkg;

  localparam int DEF_MAX_FIELDS = 16;

  localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

  typedef enum logic [1:0] {
    TYPE_MAIN     = 2'd0,
    TYPE_GLOBAL   = 2'd1,
    TYPE_LOCAL    = 2'd2,
    TYPE_RESERVED = 2'd3
  } item_type_e;

  localparam logic [3:0] TAG_USAGE_PAGE   = 4'h0;
  localparam logic [3:0] TAG_LOGICAL_MIN  = 4'h1;
  localparam logic [3:0] TAG_LOGICAL_MAX  = 4'h2;
  localparam logic [3:0] TAG_REPORT_SIZE  = 4'h7;
  localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;
  localparam logic [3:0] TAG_USAGE        = 4'h0;
  localparam logic [3:0] TAG_INPUT        = 4'h8;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic               has_field;
    logic [15:0]        field_page;
    logic [15:0]        field_usage;
    logic signed [31:0] field_min;
    logic signed [31:0] field_max;
    logic [15:0]        bit_size;
    logic [15:0]        element_count;
    logic [7:0]         id_of_report;
    logic               relative_flag;
    logic               variable_flag;
    logic               end_of_descriptor;
    logic [4:0]         fields_found;
  } out_t;

  typedef struct packed {
    logic        complete;
    item_type_e  item_type;
    logic [3:0]  tag;
    logic [31:0] value;
  } item_t;

endpackage

`default_nettype wire

/* hw/rtl/hrdp_assembler.sv */
// Collects a prefix byte and its data bytes into one complete short item.
// Depends on hrdp_pkg.
`default_nettype none

module hrdp_assembler
  import hrdp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [7:0] desc_byte,
  input  wire logic       last_byte,
  output item_t           item
);

  logic [2:0]  pending;
  logic [7:0]  prefix;
  logic [31:0] data_shift;
  logic [2:0]  pending_next;
  logic [7:0]  prefix_next;
  logic [31:0] data_shift_next;
  logic        complete;

  always_comb begin
    if (pending == 3'd0) begin
      prefix_next     = desc_byte;
      data_shift_next = 32'd0;
      pending_next    = (desc_byte[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, desc_byte[1:0]};
      complete        = (desc_byte[1:0] == 2'd0);
    end else begin
      prefix_next     = prefix;
      data_shift_next = {desc_byte, data_shift[31:8]};
      pending_next    = pending - 3'd1;
      complete        = (pending == 3'd1);
    end
  end

  always_comb begin
    item.complete  = complete;
    item.item_type = item_type_e'(prefix_next[3:2]);
    item.tag       = prefix_next[7:4];
    unique case (prefix_next[1:0])
      2'd0: item.value = 32'd0;
      2'd1: item.value = {24'd0, data_shift_next[31:24]};
      2'd2: item.value = {{16{data_shift_next[31]}}, data_shift_next[31:16]};
      default: item.value = data_shift_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 3'd0;
      prefix     <= 8'd0;
      data_shift <= 32'd0;
    end else if (advance) begin
      if (last_byte) begin
        pending    <= 3'd0;
        prefix     <= 8'd0;
        data_shift <= 32'd0;
      end else begin
        pending    <= pending_next;
        prefix     <= prefix_next;
        data_shift <= data_shift_next;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hrdp_executor.sv */
// Applies completed items to the global and local state and forms field records.
// Depends on hrdp_pkg.
`default_nettype none

module hrdp_executor
  import hrdp_pkg::*;
#(
  parameter int MAX_FIELDS = DEF_MAX_FIELDS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic last_byte,
  input  item_t     item,
  output logic      emit,
  output out_t      result
);

  localparam int TW = $clog2(MAX_FIELDS + 1);

  logic [15:0]   page_reg;
  logic [31:0]   min_reg;
  logic [31:0]   max_reg;
  logic [15:0]   size_reg;
  logic [15:0]   count_reg;
  logic [7:0]    id_reg;
  logic [15:0]   usage_reg;
  logic [TW-1:0] field_total;
  logic [TW-1:0] field_total_next;
  logic [31:0]   total_wide;
  logic          is_global;
  logic          is_local;
  logic          record;

  always_comb begin
    is_global = item.complete && (item.item_type == TYPE_GLOBAL);
    is_local  = item.complete && (item.item_type == TYPE_LOCAL);
    record    = item.complete && (item.item_type == TYPE_MAIN) &&
                (item.tag == TAG_INPUT) && (field_total < TW'(MAX_FIELDS));
    field_total_next = record ? field_total + 1'b1 : field_total;
    total_wide       = 32'(field_total_next);
    emit             = record || last_byte;

    result                   = '0;
    result.end_of_descriptor = last_byte;
    result.fields_found      = total_wide[4:0];
    if (record) begin
      result.has_field     = 1'b1;
      result.field_page    = page_reg;
      result.field_usage   = usage_reg;
      result.field_min     = min_reg;
      result.field_max     = max_reg;
      result.bit_size      = size_reg;
      result.element_count = count_reg;
      result.id_of_report  = id_reg;
      result.relative_flag = item.value[2];
      result.variable_flag = item.value[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      page_reg    <= 16'd0;
      min_reg     <= 32'd0;
      max_reg     <= 32'd0;
      size_reg    <= 16'd0;
      count_reg   <= 16'd0;
      id_reg      <= 8'd0;
      usage_reg   <= 16'd0;
      field_total <= '0;
    end else if (advance) begin
      field_total <= field_total_next;
      if (is_global) begin
        unique case (item.tag)
          TAG_USAGE_PAGE:   page_reg  <= item.value[15:0];
          TAG_LOGICAL_MIN:  min_reg   <= item.value;
          TAG_LOGICAL_MAX:  max_reg   <= item.value;
          TAG_REPORT_SIZE:  size_reg  <= item.value[15:0];
          TAG_REPORT_ID:    id_reg    <= item.value[7:0];
          TAG_REPORT_COUNT: count_reg <= item.value[15:0];
          default: ;
        endcase
      end
      if (is_local && (item.tag == TAG_USAGE)) begin
        usage_reg <= item.value[15:0];
      end
      if (record) begin
        usage_reg <= 16'd0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hid_report_descriptor_parser.sv */
// Top level of the HID report descriptor parser.
// Depends on hrdp_pkg, hrdp_assembler and hrdp_executor.
//
// The input channel takes one descriptor byte per transaction, with last_byte
// marking the final byte. The output channel carries a transaction for every
// byte that completes an Input main item while the record limit is not yet
// reached, and for the final byte, which also has end_of_descriptor set.
// Bytes that produce no record and are not final give no output transaction.
// An accepted byte waits in the input register until the output register is
// empty or drained in the same cycle; it is processed then, and its result is registered into the output register.
// One byte is taken per cycle as long as the output register is empty or
// drained in the same cycle; the byte decode and state update are the only
// logic between the input and result registers.
// Reset clears all parser state and both valid flags. After the final byte the
// parser returns to its reset state on its own. When the receiver stalls, the
// result waits in the output register and the input register holds the next
// byte, so in_ready falls only while both are occupied.
`default_nettype none

module hid_report_descriptor_parser
  import hrdp_pkg::*;
#(
  parameter int MAX_FIELDS = DEF_MAX_FIELDS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_t       in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_item
);

  logic  held;
  in_t   held_item;
  logic  advance;
  logic  emit;
  item_t item;
  out_t  result;

  assign advance  = held && (!out_valid || out_ready);
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

  hrdp_assembler u_assembler (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .desc_byte (held_item.desc_byte),
    .last_byte (held_item.last_byte),
    .item      (item)
  );

  hrdp_executor #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_executor (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .last_byte (held_item.last_byte),
    .item      (item),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the HID report descriptor parser.
// Depends on hrdp_pkg and hid_report_descriptor_parser; a clocked driver and monitor
// check every output transaction against a built-in parser model.
`default_nettype none

module testbench;
  import hrdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_BYTES = 1050;
  localparam int QUIET_TAIL   = 120;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  hid_report_descriptor_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_t        byte_q[$];
  logic [7:0] desc_bytes[$];
  out_t       record_q[$];

  int errors = 0;
  int desc_total = 0;
  int bytes_sent = 0;
  int records_seen = 0;
  int ends_seen = 0;
  int cycles = 0;
  logic quiet = 1'b0;

  // Parser model state.
  logic [2:0]  pend_bytes = '0;
  logic [7:0]  cur_prefix = '0;
  logic [31:0] cur_data = '0;
  logic [15:0] g_page = '0;
  logic signed [31:0] g_min = '0;
  logic signed [31:0] g_max = '0;
  logic [15:0] g_size = '0;
  logic [15:0] g_count = '0;
  logic [7:0]  g_id = '0;
  logic [15:0] l_usage = '0;
  int unsigned field_count = 0;

  function automatic logic [2:0] bytes_of(logic [1:0] code);
    return (code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, code};
  endfunction

  function automatic void clear_parser();
    pend_bytes = '0;
    cur_prefix = '0;
    cur_data = '0;
    g_page = '0;
    g_min = '0;
    g_max = '0;
    g_size = '0;
    g_count = '0;
    g_id = '0;
    l_usage = '0;
    field_count = 0;
  endfunction

  function automatic void parse_byte(in_t t);
    out_t       r;
    logic       done;
    logic       rec;
    logic [31:0] v;
    item_type_e ty;
    logic [3:0] tg;
    r = '0;
    rec = 1'b0;
    if (pend_bytes == 3'd0) begin
      cur_prefix = t.desc_byte;
      cur_data = '0;
      pend_bytes = bytes_of(t.desc_byte[1:0]);
      done = (pend_bytes == 3'd0);
    end else begin
      cur_data = {t.desc_byte, cur_data[31:8]};
      pend_bytes = pend_bytes - 3'd1;
      done = (pend_bytes == 3'd0);
    end
    if (done) begin
      ty = item_type_e'(cur_prefix[3:2]);
      tg = cur_prefix[7:4];
      case (bytes_of(cur_prefix[1:0]))
        3'd1: v = {24'd0, cur_data[31:24]};
        3'd2: v = {{16{cur_data[31]}}, cur_data[31:16]};
        3'd4: v = cur_data;
        default: v = '0;
      endcase
      case (ty)
        TYPE_GLOBAL: begin
          case (tg)
            TAG_USAGE_PAGE:   g_page = v[15:0];
            TAG_LOGICAL_MIN:  g_min = v;
            TAG_LOGICAL_MAX:  g_max = v;
            TAG_REPORT_SIZE:  g_size = v[15:0];
            TAG_REPORT_ID:    g_id = v[7:0];
            TAG_REPORT_COUNT: g_count = v[15:0];
            default: ;
          endcase
        end
        TYPE_LOCAL: begin
          if (tg == TAG_USAGE) l_usage = v[15:0];
        end
        TYPE_MAIN: begin
          if (tg == TAG_INPUT && field_count < DEF_MAX_FIELDS) begin
            r.has_field = 1'b1;
            r.field_page = g_page;
            r.field_usage = l_usage;
            r.field_min = g_min;
            r.field_max = g_max;
            r.bit_size = g_size;
            r.element_count = g_count;
            r.id_of_report = g_id;
            r.relative_flag = v[2];
            r.variable_flag = v[1];
            field_count++;
            l_usage = '0;
            rec = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (rec || t.last_byte) begin
      r.end_of_descriptor = t.last_byte;
      r.fields_found = field_count[4:0];
      record_q.push_back(r);
      if (t.last_byte) clear_parser();
    end
  endfunction

  task automatic push_item(logic [7:0] pre, logic [31:0] val);
    desc_bytes.push_back(pre);
    for (int i = 0; i < int'(bytes_of(pre[1:0])); i++) desc_bytes.push_back(val[8*i +: 8]);
  endtask

  task automatic close_desc(int drop);
    in_t        t;
    repeat (drop) begin
      if (desc_bytes.size() > 1) desc_bytes.delete(desc_bytes.size() - 1);
    end
    while (desc_bytes.size() > 0) begin
      t.desc_byte = desc_bytes.pop_front();
      t.last_byte = (desc_bytes.size() == 0);
      byte_q.push_back(t);
    end
    desc_total++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_8000;
      5: return 32'h0000_7FFF;
      6: return 32'h0000_00FF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_global_tag();
    case ($urandom_range(0, 6))
      0: return TAG_USAGE_PAGE;
      1: return TAG_LOGICAL_MIN;
      2: return TAG_LOGICAL_MAX;
      3: return TAG_REPORT_SIZE;
      4: return TAG_REPORT_ID;
      5: return TAG_REPORT_COUNT;
      default: return 4'($urandom);
    endcase
  endfunction

  task automatic add_random_item(int input_weight);
    int         k;
    logic [1:0] sz;
    logic [7:0] pre;
    k = $urandom_range(0, 99);
    sz = 2'($urandom);
    if (k < input_weight) begin
      if ($urandom_range(0, 3) != 0) sz = 2'd1;
      pre = {TAG_INPUT, 2'(TYPE_MAIN), sz};
    end else if (k < input_weight + 35) begin
      pre = {pick_global_tag(), 2'(TYPE_GLOBAL), sz};
    end else if (k < input_weight + 50) begin
      pre = {($urandom_range(0, 3) != 0) ? TAG_USAGE : 4'($urandom), 2'(TYPE_LOCAL), sz};
    end else if ($urandom_range(0, 3) == 0) begin
      pre = 8'hFE;
    end else begin
      pre = 8'($urandom);
    end
    push_item(pre, pick_value());
  endtask

  task automatic add_random_desc();
    int n;
    int weight;
    case ($urandom_range(0, 9))
      0: begin
        repeat ($urandom_range(1, 12)) desc_bytes.push_back(8'($urandom));
        close_desc(0);
      end
      1: begin
        weight = 75;
        n = $urandom_range(24, 32);
        repeat (n) add_random_item(weight);
        close_desc(0);
      end
      default: begin
        weight = 30;
        n = $urandom_range(2, 20);
        repeat (n) add_random_item(weight);
        if ($urandom_range(0, 4) == 0) begin
          push_item({pick_global_tag(), 2'(TYPE_GLOBAL), SIZE_CODE_FOUR}, $urandom);
          close_desc($urandom_range(1, 4));
        end else begin
          close_desc(0);
        end
      end
    endcase
  endtask

  // Driver: offers queued bytes and updates the model on every accepted transaction.
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_item);
        bytes_sent++;
      end
      quiet <= (byte_q.size() < QUIET_TAIL);
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_item <= byte_q.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts and one long hold-off to back up the input.
  int stall_left = 0;
  int hold_left = 0;
  int taken = 0;
  logic long_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) taken++;
      if (!long_done && taken >= 40) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  out_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (record_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got %p", $time, out_item);
        errors++;
      end else begin
        want = record_q.pop_front();
        if (out_item.has_field) records_seen++;
        if (out_item.end_of_descriptor) ends_seen++;
        check_field("has_field", want.has_field, out_item.has_field);
        check_field("field_page", want.field_page, out_item.field_page);
        check_field("field_usage", want.field_usage, out_item.field_usage);
        check_field("field_min", want.field_min, out_item.field_min);
        check_field("field_max", want.field_max, out_item.field_max);
        check_field("bit_size", want.bit_size, out_item.bit_size);
        check_field("element_count", want.element_count, out_item.element_count);
        check_field("id_of_report", want.id_of_report, out_item.id_of_report);
        check_field("relative_flag", want.relative_flag, out_item.relative_flag);
        check_field("variable_flag", want.variable_flag, out_item.variable_flag);
        check_field("end_of_descriptor", want.end_of_descriptor, out_item.end_of_descriptor);
        check_field("fields_found", want.fields_found, out_item.fields_found);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, record_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // A lone main item with no data as the whole descriptor.
    push_item(8'h00, 32'h0);
    close_desc(0);
    // A record and the end marker on the same byte.
    push_item({TAG_USAGE, 2'(TYPE_LOCAL), 2'd1}, 32'h0000_0001);
    push_item({TAG_INPUT, 2'(TYPE_MAIN), 2'd0}, 32'h0);
    close_desc(0);
    // Extreme globals, narrow truncation, both flags, then a truncated trailing item.
    push_item({TAG_USAGE_PAGE, 2'(TYPE_GLOBAL), 2'd1}, 32'h0000_00FF);
    push_item({TAG_LOGICAL_MIN, 2'(TYPE_GLOBAL), 2'd2}, 32'h0000_8000);
    push_item({TAG_LOGICAL_MAX, 2'(TYPE_GLOBAL), SIZE_CODE_FOUR}, 32'h7FFF_FFFF);
    push_item({TAG_REPORT_SIZE, 2'(TYPE_GLOBAL), 2'd1}, 32'h0000_0080);
    push_item({TAG_REPORT_COUNT, 2'(TYPE_GLOBAL), 2'd1}, 32'h0000_00FF);
    push_item({TAG_REPORT_ID, 2'(TYPE_GLOBAL), 2'd1}, 32'h0000_00FF);
    push_item({TAG_USAGE, 2'(TYPE_LOCAL), 2'd2}, 32'h0000_FFFF);
    push_item({TAG_INPUT, 2'(TYPE_MAIN), 2'd1}, 32'h0000_0006);
    push_item({TAG_LOGICAL_MAX, 2'(TYPE_GLOBAL), 2'd2}, 32'h0000_1234);
    close_desc(1);

    while (byte_q.size() < TARGET_BYTES) add_random_desc();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (record_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d descriptors; checked %0d field records and %0d end markers.",
             bytes_sent, desc_total, records_seen, ends_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
